FILE: hdl/bwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwd_pkg - shared definitions for the blitter word datapath
// Word size, configuration register indexes, fill mode codes and the control
// group that the top level hands to the word logic.
// ----------------------------------------------------------------------------
package bwd_pkg;

    // Data word size
    localparam int WORD_BITS = 16;

    // Configuration port widths
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 8;
    localparam int MINTERM_BITS   = 8;
    localparam int FILL_MODE_BITS = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHIFT_A       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHIFT_B       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MINTERM       = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DESCENDING    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FILL_MODE     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FILL_CARRY_IN = 3'd5;

    // Fill mode codes; bit 1 selects exclusive fill and wins over bit 0
    localparam logic [FILL_MODE_BITS-1:0] FILL_NONE      = 2'd0;
    localparam logic [FILL_MODE_BITS-1:0] FILL_INCLUSIVE = 2'd1;
    localparam logic [FILL_MODE_BITS-1:0] FILL_EXCLUSIVE = 2'd2;
    localparam int                        FILL_EXCL_BIT  = 1;

    // Control group for the word logic
    typedef struct packed {
        logic [MINTERM_BITS-1:0] minterm_table;
        logic                    descending;
        logic                    fill_en;
        logic                    fill_excl;
    } t_logic_ctrl;

endpackage

FILE: hdl/bwd_word_logic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwd_word_logic - shifters, minterm logic and area fill for one word
// Purely combinational: joins the new A and B words with their previous
// words through barrel shifters, combines with C through the minterm truth
// table and applies the optional inclusive or exclusive fill.
// ----------------------------------------------------------------------------
module bwd_word_logic #(
    parameter int WORD_BITS = bwd_pkg::WORD_BITS
) (
    input  logic [WORD_BITS-1:0]          i_a_new,
    input  logic [WORD_BITS-1:0]          i_b_new,
    input  logic [WORD_BITS-1:0]          i_c_new,
    input  logic [WORD_BITS-1:0]          i_a_prev,
    input  logic [WORD_BITS-1:0]          i_b_prev,
    input  logic [$clog2(WORD_BITS)-1:0]  i_shift_a,
    input  logic [$clog2(WORD_BITS)-1:0]  i_shift_b,
    input  bwd_pkg::t_logic_ctrl          i_ctrl,
    input  logic                          i_carry,
    output logic [WORD_BITS-1:0]          o_a_shifted,
    output logic [WORD_BITS-1:0]          o_b_shifted,
    output logic [WORD_BITS-1:0]          o_d_word,
    output logic                          o_carry
);

    localparam int SHIFT_BITS = $clog2(WORD_BITS);

    // Ascending: low word of (prev:new) >> n. Descending: high word of
    // (new:prev) << n. A zero shift gives the new word either way.
    function automatic logic [WORD_BITS-1:0] barrel(
        input logic [WORD_BITS-1:0]  fresh,
        input logic [WORD_BITS-1:0]  prior,
        input logic [SHIFT_BITS-1:0] amount,
        input logic                  desc
    );
        logic [2*WORD_BITS-1:0] joined;
        if (desc) begin
            joined = {fresh, prior} << amount;
            return joined[2*WORD_BITS-1:WORD_BITS];
        end
        joined = {prior, fresh} >> amount;
        return joined[WORD_BITS-1:0];
    endfunction

    logic [WORD_BITS-1:0] a_sh;
    logic [WORD_BITS-1:0] b_sh;
    logic [WORD_BITS-1:0] d_logic;
    logic [WORD_BITS-1:0] d_fill;

    assign a_sh = barrel(i_a_new, i_a_prev, i_shift_a, i_ctrl.descending);
    assign b_sh = barrel(i_b_new, i_b_prev, i_shift_b, i_ctrl.descending);

    // Minterm: each result bit is the table entry addressed by {a, b, c}
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            d_logic[i] = i_ctrl.minterm_table[{a_sh[i], b_sh[i], i_c_new[i]}];
        end
    end

    // Fill: carry at bit i is the incoming carry xor parity of the bits below
    always_comb begin
        logic [WORD_BITS-1:0] below;
        logic                 carry_i;
        for (int i = 0; i < WORD_BITS; i++) begin
            below   = (WORD_BITS'(1) << i) - WORD_BITS'(1);
            carry_i = i_carry ^ (^(d_logic & below));
            if (carry_i) begin
                d_fill[i] = i_ctrl.fill_excl ? ~d_logic[i] : 1'b1;
            end else begin
                d_fill[i] = d_logic[i];
            end
        end
    end

    assign o_a_shifted = a_sh;
    assign o_b_shifted = b_sh;
    assign o_d_word    = i_ctrl.fill_en ? d_fill : d_logic;
    assign o_carry     = i_ctrl.fill_en ? (i_carry ^ (^d_logic)) : i_carry;

endmodule

FILE: hdl/blitter_word_datapath.sv
`timescale 1ns / 1ps
// A request waits in the input register and is presented from the result
// register. One request per cycle while the result stream is ready; the whole
// word path is one pass of logic between the input and the result register.
// Reset (synchronous, active low) clears both register valids, all
// configuration registers, the previous A and B words and the fill carry.
// ----------------------------------------------------------------------------
// blitter_word_datapath - word datapath of a bit-plane block mover
// Barrel shifters for A and B, minterm logic over A, B and C and area fill,
// with a streaming input, a streaming result and a register write port.
// ----------------------------------------------------------------------------
module blitter_word_datapath #(
    parameter int WORD_BITS = bwd_pkg::WORD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bwd_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [bwd_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // Input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: a_word, b_word, c_word (from bit 0 up)
    input  logic [((3*WORD_BITS+7)/8)*8-1:0]    i_s_tdata,
    // tuser: row_start
    input  logic                                i_s_tuser,
    // Result stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tdata: a_shifted, b_shifted, d_word (from bit 0 up)
    output logic [((3*WORD_BITS+7)/8)*8-1:0]    o_m_tdata,
    // tuser: d_zero
    output logic                                o_m_tuser
);

    localparam int SHIFT_BITS = $clog2(WORD_BITS);
    localparam int TDATA_BITS = ((3*WORD_BITS+7)/8)*8;

    // Configuration registers
    logic [SHIFT_BITS-1:0]                     r_shift_a;
    logic [SHIFT_BITS-1:0]                     r_shift_b;
    logic [bwd_pkg::MINTERM_BITS-1:0]          r_minterm;
    logic                                      r_descending;
    logic [bwd_pkg::FILL_MODE_BITS-1:0]        r_fill_mode;
    logic                                      r_fill_carry_in;

    // Datapath state
    logic [WORD_BITS-1:0] r_a_prev;
    logic [WORD_BITS-1:0] r_b_prev;
    logic                 r_fill_carry;

    // Input register
    logic                 r_s1_valid;
    logic [WORD_BITS-1:0] r_s1_a;
    logic [WORD_BITS-1:0] r_s1_b;
    logic [WORD_BITS-1:0] r_s1_c;
    logic                 r_s1_row;

    // Result register
    logic                 r_s2_valid;
    logic [WORD_BITS-1:0] r_s2_a_sh;
    logic [WORD_BITS-1:0] r_s2_b_sh;
    logic [WORD_BITS-1:0] r_s2_d;
    logic                 r_s2_zero;

    logic                 s_accept;
    logic                 s1_advance;
    logic                 carry_start;
    logic                 n_fill_carry;
    bwd_pkg::t_logic_ctrl ctrl;
    logic [WORD_BITS-1:0] a_sh;
    logic [WORD_BITS-1:0] b_sh;
    logic [WORD_BITS-1:0] d_word;

    // Configuration port is always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_a       <= '0;
            r_shift_b       <= '0;
            r_minterm       <= '0;
            r_descending    <= 1'b0;
            r_fill_mode     <= bwd_pkg::FILL_NONE;
            r_fill_carry_in <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bwd_pkg::REG_SHIFT_A:       r_shift_a       <= i_cfg_data[SHIFT_BITS-1:0];
                bwd_pkg::REG_SHIFT_B:       r_shift_b       <= i_cfg_data[SHIFT_BITS-1:0];
                bwd_pkg::REG_MINTERM:       r_minterm       <= i_cfg_data[bwd_pkg::MINTERM_BITS-1:0];
                bwd_pkg::REG_DESCENDING:    r_descending    <= i_cfg_data[0];
                bwd_pkg::REG_FILL_MODE:     r_fill_mode     <= i_cfg_data[bwd_pkg::FILL_MODE_BITS-1:0];
                bwd_pkg::REG_FILL_CARRY_IN: r_fill_carry_in <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Handshake: the input register moves on when the result register is free
    assign s1_advance = r_s1_valid && (!r_s2_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_advance;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_a   <= i_s_tdata[WORD_BITS-1:0];
            r_s1_b   <= i_s_tdata[2*WORD_BITS-1:WORD_BITS];
            r_s1_c   <= i_s_tdata[3*WORD_BITS-1:2*WORD_BITS];
            r_s1_row <= i_s_tuser;
        end
    end

    // Word logic
    assign carry_start    = r_s1_row ? r_fill_carry_in : r_fill_carry;
    assign ctrl.minterm_table = r_minterm;
    assign ctrl.descending    = r_descending;
    assign ctrl.fill_en       = (r_fill_mode != bwd_pkg::FILL_NONE);
    assign ctrl.fill_excl     = r_fill_mode[bwd_pkg::FILL_EXCL_BIT];

    bwd_word_logic #(
        .WORD_BITS (WORD_BITS)
    ) u_word_logic (
        .i_a_new     (r_s1_a),
        .i_b_new     (r_s1_b),
        .i_c_new     (r_s1_c),
        .i_a_prev    (r_a_prev),
        .i_b_prev    (r_b_prev),
        .i_shift_a   (r_shift_a),
        .i_shift_b   (r_shift_b),
        .i_ctrl      (ctrl),
        .i_carry     (carry_start),
        .o_a_shifted (a_sh),
        .o_b_shifted (b_sh),
        .o_d_word    (d_word),
        .o_carry     (n_fill_carry)
    );

    // State moves with each word that enters the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_prev     <= '0;
            r_b_prev     <= '0;
            r_fill_carry <= 1'b0;
        end else if (s1_advance) begin
            r_a_prev     <= r_s1_a;
            r_b_prev     <= r_s1_b;
            r_fill_carry <= n_fill_carry;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_advance) begin
            r_s2_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_s2_a_sh <= a_sh;
            r_s2_b_sh <= b_sh;
            r_s2_d    <= d_word;
            r_s2_zero <= (d_word == '0);
        end
    end

    assign o_m_tvalid = r_s2_valid;
    assign o_m_tdata  = TDATA_BITS'({r_s2_d, r_s2_b_sh, r_s2_a_sh});
    assign o_m_tuser  = r_s2_zero;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for blitter_word_datapath
// Sends word requests and register writes, predicts every result with a
// behavioural model of the shifters, minterm logic and area fill, and checks
// each result in order while both streams idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WORD_BITS      = bwd_pkg::WORD_BITS;
    localparam int CFG_INDEX_BITS = bwd_pkg::CFG_INDEX_BITS;
    localparam int CFG_DATA_BITS  = bwd_pkg::CFG_DATA_BITS;
    localparam int DATA_BITS      = ((3*WORD_BITS+7)/8)*8;
    localparam int RANDOM_WORDS   = 700;
    localparam int HOLD_CYCLES    = 60;

    // Indexes past the last register: writes there must change nothing
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        bit                 d_zero;
        bit [WORD_BITS-1:0] d_word;
        bit [WORD_BITS-1:0] b_shifted;
        bit [WORD_BITS-1:0] a_shifted;
    } t_result;

    // Word path model plus the queue of result words still owed by the block
    class word_path_model;
        bit [3:0]           shift_a;
        bit [3:0]           shift_b;
        bit [7:0]           minterms;
        bit                 descending;
        bit [1:0]           fill_mode;
        bit                 carry_in;
        bit [WORD_BITS-1:0] a_prev;
        bit [WORD_BITS-1:0] b_prev;
        bit                 carry;
        t_result            expected_words[$];
        int                 errors;

        function void write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [7:0] value);
            case (index)
                bwd_pkg::REG_SHIFT_A:       shift_a    = value[3:0];
                bwd_pkg::REG_SHIFT_B:       shift_b    = value[3:0];
                bwd_pkg::REG_MINTERM:       minterms   = value;
                bwd_pkg::REG_DESCENDING:    descending = value[0];
                bwd_pkg::REG_FILL_MODE:     fill_mode  = value[1:0];
                bwd_pkg::REG_FILL_CARRY_IN: carry_in   = value[0];
                default: ;
            endcase
        endfunction

        // Join new and previous word, then shift towards the new one
        function bit [WORD_BITS-1:0] barrel(bit [WORD_BITS-1:0] fresh,
                                            bit [WORD_BITS-1:0] prior, bit [3:0] amount);
            bit [2*WORD_BITS-1:0] joined;
            if (descending) begin
                joined = {fresh, prior} << amount;
                return joined[2*WORD_BITS-1:WORD_BITS];
            end
            joined = {prior, fresh} >> amount;
            return joined[WORD_BITS-1:0];
        endfunction

        function void note_request(bit [WORD_BITS-1:0] a_word, b_word, c_word,
                                   bit row_start);
            t_result            res;
            bit [WORD_BITS-1:0] logic_out;
            bit                 run;
            res.a_shifted = barrel(a_word, a_prev, shift_a);
            res.b_shifted = barrel(b_word, b_prev, shift_b);
            a_prev = a_word;
            b_prev = b_word;
            // row start reloads the carry even with fill off
            if (row_start)
                carry = carry_in;
            for (int i = 0; i < WORD_BITS; i++)
                logic_out[i] = minterms[{res.a_shifted[i], res.b_shifted[i], c_word[i]}];
            res.d_word = logic_out;
            // fill from bit 0 up; exclusive wins when both mode bits are set
            if (fill_mode != bwd_pkg::FILL_NONE) begin
                run = carry;
                for (int i = 0; i < WORD_BITS; i++) begin
                    if (run)
                        res.d_word[i] = fill_mode[bwd_pkg::FILL_EXCL_BIT] ?
                                        ~logic_out[i] : 1'b1;
                    if (logic_out[i])
                        run = ~run;
                end
                carry = run;
            end
            res.d_zero = (res.d_word == '0);
            expected_words.push_back(res);
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        task check_result(logic [DATA_BITS-1:0] data, logic zero);
            t_result want;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected result %h zero=%b", data, zero));
                return;
            end
            want = expected_words.pop_front();
            if (data[WORD_BITS-1:0] !== want.a_shifted)
                report($sformatf("a_shifted %h, want %h", data[WORD_BITS-1:0],
                                 want.a_shifted));
            if (data[2*WORD_BITS-1:WORD_BITS] !== want.b_shifted)
                report($sformatf("b_shifted %h, want %h", data[2*WORD_BITS-1:WORD_BITS],
                                 want.b_shifted));
            if (data[3*WORD_BITS-1:2*WORD_BITS] !== want.d_word)
                report($sformatf("d_word %h, want %h", data[3*WORD_BITS-1:2*WORD_BITS],
                                 want.d_word));
            if (zero !== want.d_zero)
                report($sformatf("d_zero %b, want %b", zero, want.d_zero));
        endtask

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [DATA_BITS-1:0]      s_tdata   = '0;
    logic                      s_tuser   = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [DATA_BITS-1:0]      m_tdata;
    logic                      m_tuser;

    word_path_model path_model = new();
    int             hold_cycles = 0;
    int             tx_count    = 0;
    bit             tx_idle_on  = 1'b0;

    blitter_word_datapath u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

    // 100 MHz clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Register write; the channel goes idle again before the task returns
    task automatic write_config(input logic [CFG_INDEX_BITS-1:0] index,
                                input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        path_model.write_reg(index, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One word request, after a random gap; idling switches on and off in runs
    task automatic send_word(input bit [WORD_BITS-1:0] a_word, b_word, c_word,
                             input bit row_start);
        int gap;
        if (tx_count % 16 == 0)
            tx_idle_on = ($urandom_range(0, 2) != 0);
        tx_count++;
        gap = tx_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c_word, b_word, a_word};
        s_tuser  <= row_start;
        do @(posedge clk); while (s_tready !== 1'b1);
        path_model.note_request(a_word, b_word, c_word, row_start);
    endtask

    // Stop sending and let every owed result come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (path_model.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Dense random words half the time, else all-zero, all-one, one-hot or one-cold
    function automatic bit [WORD_BITS-1:0] pick_word();
        bit [WORD_BITS-1:0] w;
        w = WORD_BITS'($urandom);
        case ($urandom_range(0, 7))
            0: w = '0;
            1: w = '1;
            2: w = WORD_BITS'(1) << $urandom_range(0, WORD_BITS-1);
            3: w = ~(WORD_BITS'(1) << $urandom_range(0, WORD_BITS-1));
            default: ;
        endcase
        return w;
    endfunction

    // Register values: extremes often, any byte otherwise (upper bits unused)
    function automatic bit [CFG_DATA_BITS-1:0] pick_setting();
        bit [CFG_DATA_BITS-1:0] v;
        v = CFG_DATA_BITS'($urandom);
        case ($urandom_range(0, 3))
            0: v = '0;
            1: v = '1;
            default: ;
        endcase
        return v;
    endfunction

    // Result side: random stalls, plus one long hold-off when asked for
    initial begin : result_sink
        int stall;
        int seen;
        bit idle_on;
        seen = 0;
        idle_on = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (seen % 16 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            seen++;
            stall = idle_on ? $urandom_range(0, 7) : 0;
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            path_model.check_result(m_tdata, m_tuser);
        end
    end

    initial begin : stimulus
        int sent;
        int phase;
        int len;
        int row_left;
        bit row;
        sent = 0;
        phase = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // writes past the last register are dropped; reset values still hold
        write_config(REG_SPARE_6, 8'hFF);
        write_config(REG_SPARE_7, 8'hFF);
        send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_word(16'h0000, 16'h0000, 16'h0000, 1'b0);
        drain();

        // full ascending shift, D = A; row start with fill off loads the carry
        write_config(bwd_pkg::REG_SHIFT_A, 8'h0F);
        write_config(bwd_pkg::REG_SHIFT_B, 8'hFF);
        write_config(bwd_pkg::REG_MINTERM, 8'hF0);
        write_config(bwd_pkg::REG_FILL_CARRY_IN, 8'h01);
        send_word(16'h8001, 16'h0001, 16'h1234, 1'b1);
        send_word(16'hFFFF, 16'h8000, 16'h0000, 1'b0);
        send_word(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
        drain();

        // descending: zero shift on A, full shift on B, D = B
        write_config(bwd_pkg::REG_DESCENDING, 8'h01);
        write_config(bwd_pkg::REG_SHIFT_A, 8'h00);
        write_config(bwd_pkg::REG_MINTERM, 8'hCC);
        send_word(16'h1234, 16'h8001, 16'h0000, 1'b0);
        send_word(16'h8000, 16'h0001, 16'h5555, 1'b1);
        send_word(16'hFFFF, 16'hFFFF, 16'hAAAA, 1'b0);
        drain();

        // inclusive fill of A&B&C, carry passed from word to word
        write_config(bwd_pkg::REG_DESCENDING, 8'h00);
        write_config(bwd_pkg::REG_SHIFT_B, 8'h00);
        write_config(bwd_pkg::REG_MINTERM, 8'h80);
        write_config(bwd_pkg::REG_FILL_MODE, CFG_DATA_BITS'(bwd_pkg::FILL_INCLUSIVE));
        write_config(bwd_pkg::REG_FILL_CARRY_IN, 8'h00);
        send_word(16'h0010, 16'h0010, 16'h0010, 1'b1);
        send_word(16'h0100, 16'h0100, 16'h0100, 1'b0);
        send_word(16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_word(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_word(16'h0000, 16'h0000, 16'h0000, 1'b1);
        drain();

        // both fill bits set: exclusive fill must win
        write_config(bwd_pkg::REG_FILL_MODE,
                     CFG_DATA_BITS'(bwd_pkg::FILL_INCLUSIVE | bwd_pkg::FILL_EXCLUSIVE));
        write_config(bwd_pkg::REG_FILL_CARRY_IN, 8'h01);
        write_config(bwd_pkg::REG_MINTERM, 8'h01);
        send_word(16'hFFFF, 16'hFFFF, 16'hFFFE, 1'b1);
        send_word(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_word(16'h0000, 16'h0000, 16'h0000, 1'b1);
        drain();

        // exclusive fill over an all-ones table, mid shift descending
        write_config(bwd_pkg::REG_FILL_MODE, CFG_DATA_BITS'(bwd_pkg::FILL_EXCLUSIVE));
        write_config(bwd_pkg::REG_MINTERM, 8'hFF);
        write_config(bwd_pkg::REG_SHIFT_A, 8'h08);
        write_config(bwd_pkg::REG_DESCENDING, 8'h01);
        send_word(16'hA5A5, 16'h3C3C, 16'h0F0F, 1'b1);
        send_word(16'h5A5A, 16'hC3C3, 16'hF0F0, 1'b0);
        drain();

        // random phases: new settings, then rows of random words
        while (sent < RANDOM_WORDS) begin
            write_config(bwd_pkg::REG_SHIFT_A, pick_setting());
            write_config(bwd_pkg::REG_SHIFT_B, pick_setting());
            write_config(bwd_pkg::REG_MINTERM, pick_setting());
            write_config(bwd_pkg::REG_DESCENDING, pick_setting());
            write_config(bwd_pkg::REG_FILL_MODE, pick_setting());
            write_config(bwd_pkg::REG_FILL_CARRY_IN, pick_setting());
            if ($urandom_range(0, 3) == 0)
                write_config($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                             pick_setting());
            // receiver holds off while requests keep coming, so the block backs up
            if (phase % 8 == 2)
                hold_cycles = HOLD_CYCLES;
            len = $urandom_range(10, 60);
            row_left = 0;
            repeat (len) begin
                if (row_left == 0) begin
                    row = 1'b1;
                    row_left = $urandom_range(1, 8);
                end else begin
                    row = ($urandom_range(0, 15) == 0);
                end
                row_left--;
                send_word(pick_word(), pick_word(), pick_word(), row);
            end
            sent += len;
            phase++;
            drain();
        end

        repeat (8) @(posedge clk);
        if (path_model.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Run limit, far above the slowest correct run
    initial begin : watchdog
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
